/* sv/dvd_pkg.sv */
// ----------------------------------------------------------------------------
// dvd_pkg
// Shared types and constants of the duplicate value detector.
// ----------------------------------------------------------------------------
package dvd_pkg;

  localparam int VALUE_W    = 10;
  localparam int VALUE_MAX  = (1 << VALUE_W) - 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_CNT_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_CNT_W - 2;
  localparam int IN_PAD_W   = IN_DATA_W - VALUE_W;
  localparam int EPOCH_BITS = 8;

  typedef logic [EPOCH_BITS-1:0] epoch_t;

  // One map entry: list tag plus the seen and duplicate marks.
  typedef struct packed {
    epoch_t epoch;
    logic   dup;
    logic   seen;
  } entry_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

endpackage

/* sv/dvd_idx_reduce.sv */
// ----------------------------------------------------------------------------
// dvd_idx_reduce
// Folds an input value into the tracked range by conditional subtraction.
// ----------------------------------------------------------------------------
module dvd_idx_reduce import dvd_pkg::*; #(
  parameter int VALUE_RANGE = 1024,
  parameter int IDX_W       = 10
) (
  input  logic [VALUE_W-1:0] value_i,
  output logic [IDX_W-1:0]   idx_o
);

  logic [VALUE_W-1:0] rem;

  always_comb begin
    rem = value_i;
    for (int k = VALUE_W - 1; k >= 0; k--) begin
      if ((VALUE_RANGE << k) <= VALUE_MAX) begin
        if (rem >= VALUE_W'(VALUE_RANGE << k)) begin
          rem = rem - VALUE_W'(VALUE_RANGE << k);
        end
      end
    end
  end

  assign idx_o = IDX_W'(rem);

endmodule

/* sv/dvd_map_ram.sv */
// ----------------------------------------------------------------------------
// dvd_map_ram
// Single-port-write, single-port-read map memory with registered read and
// write-to-read bypass for same-address accesses in one cycle.
// ----------------------------------------------------------------------------
module dvd_map_ram import dvd_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  entry_t            wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output entry_t            rd_data_o
);

  entry_t mem [DEPTH];
  entry_t rd_q;
  entry_t byp_q;
  logic   byp_sel_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q  <= mem[rd_addr_i];
    byp_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_sel_q <= 1'b0;
    end else begin
      byp_sel_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_sel_q ? byp_q : rd_q;

endmodule

/* sv/duplicate_value_detector_top.sv */
// ----------------------------------------------------------------------------
// duplicate_value_detector_top
// Reports repeats of bounded values within a list, one beat per value.
// ----------------------------------------------------------------------------
// Input stream: tdata[9:0] is the value, tuser marks the first value of a
// new list. Output stream: one beat per input beat, in order, carrying
// is_repeat, new_duplicate and the saturating running repeat count.
// Beats pass the read stage, then the output register. Throughput is one beat
// per cycle while the receiver keeps up and no clearing pass runs, set by one
// read-modify-write of the map memory per beat; equal values on consecutive
// beats are bypassed around the memory. Each map entry carries a list tag, so
// a new list costs no clearing. After reset, and whenever the tag wraps
// (every 255th new list), a clearing pass writes every entry, one per cycle;
// tready stays low during the pass. Reset also zeroes the count.
// When the receiver stalls, the output register holds its beat and one
// further beat waits in the read stage; beyond that tready drops.
// ----------------------------------------------------------------------------
module duplicate_value_detector_top import dvd_pkg::*; #(
  parameter int VALUE_RANGE = 1024,
  parameter int COUNT_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // value[9:0], zero pad
  input  logic                  s_axis_tuser,   // first
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // is_repeat, new_duplicate,
                                                // repeat_count[15:0], pad
);

  localparam int IDX_W = $clog2(VALUE_RANGE);

  state_e state_q, state_d;
  logic   clr_active, run_active;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  epoch_t epoch_q, epoch_d;

  logic             s0_valid_q;
  logic [IDX_W-1:0] s0_idx_q;
  logic             s0_first_q;
  epoch_t           s0_epoch_q;

  logic                  out_valid_q;
  logic                  out_rep_q;
  logic                  out_nd_q;
  logic [OUT_CNT_W-1:0]  out_cnt_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_base;

  logic [IDX_W-1:0] in_idx, rd_addr, wr_addr;
  entry_t           rd_ent, wr_ent, new_ent;
  logic             wr_en;
  logic             wrap_block, start_clr, fire, accept;
  logic             hit, seen, dup;

  dvd_idx_reduce #(
    .VALUE_RANGE(VALUE_RANGE),
    .IDX_W      (IDX_W)
  ) u_idx (
    .value_i(s_axis_tdata[VALUE_W-1:0]),
    .idx_o  (in_idx)
  );

  dvd_map_ram #(
    .DEPTH (VALUE_RANGE),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_ent),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_ent)
  );

  assign wrap_block = s_axis_tuser && (epoch_q == '1);
  assign start_clr  = run_active && s_axis_tvalid && wrap_block && !s0_valid_q;
  assign fire       = s0_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = run_active && !wrap_block && (!s0_valid_q || fire);
  assign accept     = s_axis_tvalid && s_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (start_clr) begin
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt_q == IDX_W'(VALUE_RANGE - 1)) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    clr_active = 1'b0;
    run_active = 1'b0;
    unique case (state_q)
      ST_RUN:   run_active = 1'b1;
      ST_CLEAR: clr_active = 1'b1;
      default:  clr_active = 1'b1;
    endcase
  end

  always_comb begin
    clr_cnt_d = clr_active ? clr_cnt_q + 1'b1 : '0;
    epoch_d   = epoch_q;
    if (clr_active) begin
      epoch_d = '0;
    end else if (accept && s_axis_tuser) begin
      epoch_d = epoch_q + 1'b1;
    end
  end

  // Lookup and update
  always_comb begin
    hit      = (rd_ent.epoch == s0_epoch_q);
    seen     = hit && rd_ent.seen;
    dup      = hit && rd_ent.dup;
    new_ent.epoch = s0_epoch_q;
    new_ent.seen  = 1'b1;
    new_ent.dup   = dup || seen;
    cnt_base = s0_first_q ? '0 : cnt_q;
    cnt_d    = (seen && (cnt_base != '1)) ? COUNT_BITS'(cnt_base + 1'b1) : cnt_base;
  end

  assign rd_addr = (s0_valid_q && !fire) ? s0_idx_q : in_idx;
  assign wr_en   = clr_active || fire;
  assign wr_addr = clr_active ? clr_cnt_q : s0_idx_q;
  assign wr_ent  = clr_active ? entry_t'('0) : new_ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      epoch_q     <= '0;
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      epoch_q   <= epoch_d;
      if (accept) begin
        s0_valid_q <= 1'b1;
      end else if (fire) begin
        s0_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_idx_q   <= in_idx;
      s0_first_q <= s_axis_tuser;
      s0_epoch_q <= epoch_d;
    end
    if (fire) begin
      out_rep_q <= seen;
      out_nd_q  <= seen && !dup;
      out_cnt_q <= OUT_CNT_W'(cnt_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {OUT_PAD_W'(0), out_cnt_q, out_nd_q, out_rep_q};

endmodule

/* sv/dvd_checker.sv */
// ----------------------------------------------------------------------------
// dvd_checker
// Port-level checks of the duplicate value detector, bound to the top level.
// ----------------------------------------------------------------------------
module dvd_checker import dvd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata    // is_repeat, new_duplicate,
                                               // repeat_count[15:0], pad
);

  logic                 in_beat, out_beat;
  logic [OUT_CNT_W-1:0] out_cnt, prev_cnt_q;
  logic [1:0]           pend_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign out_cnt  = m_axis_tdata[OUT_CNT_W+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cnt_q <= '0;
      pend_q     <= '0;
    end else begin
      if (out_beat) begin
        prev_cnt_q <= out_cnt;
      end
      pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
    end
  end

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("output beat without a pending input beat");

  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 2'd2)
    else $error("more beats in flight than pipeline holds");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !m_axis_tdata[0] |-> (out_cnt == prev_cnt_q) || (out_cnt == '0))
    else $error("count moved on a first occurrence");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && m_axis_tdata[0] |->
      (out_cnt == OUT_CNT_W'(prev_cnt_q + 1'b1)) || (out_cnt == OUT_CNT_W'(1)) ||
      (out_cnt == prev_cnt_q))
    else $error("count did not advance on a repeat");

endmodule

bind duplicate_value_detector_top dvd_checker u_dvd_checker (.*);
